// ===== hw/rtl/lcs_pkg.sv =====
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared constants, codes and controller/datapath bundles of the LCS unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lcs_pkg;

  localparam int MAX_LEN_DEF = 64;

  localparam int FUNC_W = 2;
  localparam int SYM_W  = 8;
  localparam int TOT_W  = 7;
  localparam int DIR_W  = 2;

  localparam logic [FUNC_W-1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_START  = 2'd2;

  localparam logic [DIR_W-1:0] DIR_DIAG = 2'd1;
  localparam logic [DIR_W-1:0] DIR_UP   = 2'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic compute_init;
    logic row_init;
    logic fill_cell;
    logic row_next;
    logic tb_init;
    logic tb_rd;
    logic tb_step;
    logic pop_init;
    logic pop_rd;
    logic pop_out;
    logic empty_out;
    logic clear;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic any_empty;
    logic row_done;
    logic last_row;
    logic tb_done;
    logic depth_zero;
    logic pop_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lcs_if.sv =====
// ----------------------------------------------------------------------------
// lcs_if
// Valid/ready channels of the LCS unit: item input and result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcs_in_if import lcs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [SYM_W-1:0]  symbol;

  modport source (output valid, func, symbol, input ready);
  modport sink   (input valid, func, symbol, output ready);
endinterface

interface lcs_out_if import lcs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] out_symbol;
  logic [TOT_W-1:0] total_length;
  logic             final_flag;
  logic             empty_flag;

  modport source (output valid, out_symbol, total_length, final_flag, empty_flag,
                  input ready);
  modport sink   (input valid, out_symbol, total_length, final_flag, empty_flag,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lcs_ram.sv =====
// ----------------------------------------------------------------------------
// lcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/lcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcs_ctrl
// Sequencer: loads, row-by-row table fill, traceback and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_ctrl import lcs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [FUNC_W-1:0] in_func,
  output logic                   in_ready,
  input  wire stat_t             stat,
  output cmd_t                   cmd
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_ROW_RD   = 4'd1;
  localparam logic [3:0] ST_CELL     = 4'd2;
  localparam logic [3:0] ST_TB_RD    = 4'd3;
  localparam logic [3:0] ST_TB_EV    = 4'd4;
  localparam logic [3:0] ST_EMIT_SEL = 4'd5;
  localparam logic [3:0] ST_POP_RD   = 4'd6;
  localparam logic [3:0] ST_POP_WAIT = 4'd7;
  localparam logic [3:0] ST_EMPTY    = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_func)
            FUNC_LOAD_A: cmd.load_a = 1'b1;
            FUNC_LOAD_B: cmd.load_b = 1'b1;
            FUNC_START: begin
              if (stat.any_empty) begin
                state_nxt = ST_EMPTY;
              end else begin
                cmd.compute_init = 1'b1;
                state_nxt        = ST_ROW_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ROW_RD: begin
        cmd.row_init = 1'b1;
        state_nxt    = ST_CELL;
      end
      ST_CELL: begin
        cmd.fill_cell = 1'b1;
        if (stat.row_done) begin
          if (stat.last_row) begin
            cmd.tb_init = 1'b1;
            state_nxt   = ST_TB_RD;
          end else begin
            cmd.row_next = 1'b1;
            state_nxt    = ST_ROW_RD;
          end
        end
      end
      ST_TB_RD: begin
        cmd.tb_rd = 1'b1;
        state_nxt = ST_TB_EV;
      end
      ST_TB_EV: begin
        cmd.tb_step = 1'b1;
        state_nxt   = stat.tb_done ? ST_EMIT_SEL : ST_TB_RD;
      end
      ST_EMIT_SEL: begin
        if (stat.depth_zero) begin
          state_nxt = ST_EMPTY;
        end else begin
          cmd.pop_init = 1'b1;
          state_nxt    = ST_POP_RD;
        end
      end
      ST_POP_RD: begin
        cmd.pop_rd = 1'b1;
        state_nxt  = ST_POP_WAIT;
      end
      ST_POP_WAIT: begin
        if (stat.out_free) begin
          cmd.pop_out = 1'b1;
          if (stat.pop_last) begin
            cmd.clear = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_POP_RD;
          end
        end
      end
      ST_EMPTY: begin
        if (stat.out_free) begin
          cmd.empty_out = 1'b1;
          cmd.clear     = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // loads complete in the accept cycle; the unit never leaves idle for them
  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_a || cmd.load_b) |=> (state_r == ST_IDLE))
    else $error("load left the idle state");

  a_result_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> (cmd.pop_out || cmd.empty_out))
    else $error("strings cleared without a final result");

  a_fill_only_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.compute_init |-> !stat.any_empty)
    else $error("table fill started on an empty string");

endmodule

`default_nettype wire

// ===== hw/rtl/lcs_dpath.sv =====
// ----------------------------------------------------------------------------
// lcs_dpath
// String stores, one-row length buffer, direction table, result stack and
// the output register of the LCS unit.
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_dpath import lcs_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cmd_t             cmd,
  input  wire logic [SYM_W-1:0] in_symbol,
  input  wire logic             out_ready,
  output stat_t                 stat,
  output logic                  out_valid,
  output logic      [SYM_W-1:0] out_symbol,
  output logic      [TOT_W-1:0] total_length,
  output logic                  final_flag,
  output logic                  empty_flag
);

  localparam int AW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW     = $clog2(MAX_LEN + 1);
  localparam int DDEPTH = MAX_LEN * MAX_LEN;
  localparam int DW     = (DDEPTH > 1) ? $clog2(DDEPTH) : 1;

  // string counts and fill/traceback counters
  logic [CW-1:0] a_cnt_r, b_cnt_r;
  logic [CW-1:0] a_last, b_last;
  logic [AW-1:0] i_r;
  logic [CW-1:0] rd_j_r, wr_j_r;
  logic          v1_r;
  logic [CW-1:0] diag_r, left_r;
  logic [DW-1:0] row_base_r, cell_r;
  logic [AW-1:0] ti_r, tj_r;
  logic [DW-1:0] tr_addr_r;
  logic [CW-1:0] depth_r;
  logic [AW-1:0] ptr_r;

  // output register
  logic             out_valid_r;
  logic [SYM_W-1:0] out_sym_r;
  logic [TOT_W-1:0] out_len_r;
  logic             out_fin_r, out_emp_r;

  // RAM ports
  logic             a_we, a_re, b_we, b_re, row_we, row_re, dir_we, dir_re, stk_we, stk_re;
  logic [AW-1:0]    a_waddr, a_raddr, b_raddr, row_raddr;
  logic [SYM_W-1:0] a_rdata, b_rdata, stk_rdata;
  logic [CW-1:0]    row_rdata;
  logic [DIR_W-1:0] dir_rdata, dir_wdata;

  logic          issue;
  logic [CW-1:0] prior, cur;
  logic          tb_done;

  assign a_last = a_cnt_r - CW'(1);
  assign b_last = b_cnt_r - CW'(1);

  // ---- loads ----
  assign a_we    = cmd.load_a && (a_cnt_r < CW'(MAX_LEN));
  assign b_we    = cmd.load_b && (b_cnt_r < CW'(MAX_LEN));
  assign a_waddr = a_cnt_r[AW-1:0];

  // ---- table fill: one cell per cycle within a row, read then compute/write ----
  assign issue     = cmd.fill_cell && (rd_j_r < b_cnt_r);
  assign a_re      = cmd.row_init || cmd.tb_rd;
  assign a_raddr   = cmd.tb_rd ? ti_r : i_r;
  assign b_re      = issue;
  assign b_raddr   = rd_j_r[AW-1:0];
  assign row_re    = issue;
  assign row_raddr = rd_j_r[AW-1:0];

  // the first row sees an all-zero row above it
  assign prior = (i_r == '0) ? '0 : row_rdata;

  always_comb begin
    if (a_rdata == b_rdata) begin
      cur       = diag_r + CW'(1);
      dir_wdata = DIR_DIAG;
    end else if (prior > left_r) begin
      cur       = prior;
      dir_wdata = DIR_UP;
    end else begin
      cur       = left_r;
      dir_wdata = DIR_LEFT;
    end
  end

  assign row_we = cmd.fill_cell && v1_r;
  assign dir_we = cmd.fill_cell && v1_r;

  // ---- traceback ----
  assign dir_re = cmd.tb_rd;

  always_comb begin
    case (dir_rdata)
      DIR_DIAG: tb_done = (ti_r == '0) || (tj_r == '0);
      DIR_UP:   tb_done = (ti_r == '0);
      default:  tb_done = (tj_r == '0);
    endcase
  end

  assign stk_we = cmd.tb_step && (dir_rdata == DIR_DIAG);
  assign stk_re = cmd.pop_rd;

  // ---- status ----
  assign stat.any_empty  = (a_cnt_r == '0) || (b_cnt_r == '0);
  assign stat.row_done   = cmd.fill_cell && v1_r && (wr_j_r == b_last);
  assign stat.last_row   = (i_r == a_last[AW-1:0]);
  assign stat.tb_done    = tb_done;
  assign stat.depth_zero = (depth_r == '0);
  assign stat.pop_last   = (ptr_r == '0);
  assign stat.out_free   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_cnt_r     <= '0;
      b_cnt_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        a_cnt_r <= '0;
        b_cnt_r <= '0;
      end else begin
        if (a_we) a_cnt_r <= a_cnt_r + CW'(1);
        if (b_we) b_cnt_r <= b_cnt_r + CW'(1);
      end
      if (cmd.pop_out || cmd.empty_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.compute_init) begin
      i_r        <= '0;
      row_base_r <= '0;
      depth_r    <= '0;
    end
    if (cmd.row_init) begin
      rd_j_r <= '0;
      wr_j_r <= '0;
      v1_r   <= 1'b0;
      diag_r <= '0;
      left_r <= '0;
      cell_r <= row_base_r;
    end
    if (cmd.fill_cell) begin
      v1_r <= issue;
      if (issue) begin
        rd_j_r <= rd_j_r + CW'(1);
      end
      if (v1_r) begin
        wr_j_r <= wr_j_r + CW'(1);
        cell_r <= cell_r + DW'(1);
        diag_r <= prior;
        left_r <= cur;
      end
    end
    if (cmd.row_next) begin
      i_r        <= i_r + AW'(1);
      row_base_r <= row_base_r + DW'(MAX_LEN);
    end
    if (cmd.tb_init) begin
      // last written cell is the bottom-right corner
      ti_r      <= a_last[AW-1:0];
      tj_r      <= b_last[AW-1:0];
      tr_addr_r <= cell_r;
    end
    if (cmd.tb_step && !tb_done) begin
      case (dir_rdata)
        DIR_DIAG: begin
          ti_r      <= ti_r - AW'(1);
          tj_r      <= tj_r - AW'(1);
          tr_addr_r <= tr_addr_r - DW'(MAX_LEN + 1);
        end
        DIR_UP: begin
          ti_r      <= ti_r - AW'(1);
          tr_addr_r <= tr_addr_r - DW'(MAX_LEN);
        end
        default: begin
          tj_r      <= tj_r - AW'(1);
          tr_addr_r <= tr_addr_r - DW'(1);
        end
      endcase
    end
    if (stk_we) begin
      depth_r <= depth_r + CW'(1);
    end
    if (cmd.pop_init) begin
      ptr_r <= AW'(depth_r - CW'(1));
    end
    if (cmd.pop_out) begin
      ptr_r     <= ptr_r - AW'(1);
      out_sym_r <= stk_rdata;
      out_len_r <= TOT_W'(depth_r);
      out_fin_r <= (ptr_r == '0);
      out_emp_r <= 1'b0;
    end
    if (cmd.empty_out) begin
      out_sym_r <= '0;
      out_len_r <= '0;
      out_fin_r <= 1'b1;
      out_emp_r <= 1'b1;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_symbol   = out_sym_r;
  assign total_length = out_len_r;
  assign final_flag   = out_fin_r;
  assign empty_flag   = out_emp_r;

  // ---- memories ----
  lcs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN), .AW(AW)) u_a_ram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(in_symbol),
    .re(a_re), .raddr(a_raddr), .rdata(a_rdata)
  );

  lcs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN), .AW(AW)) u_b_ram (
    .clk(clk), .we(b_we), .waddr(b_cnt_r[AW-1:0]), .wdata(in_symbol),
    .re(b_re), .raddr(b_raddr), .rdata(b_rdata)
  );

  lcs_ram #(.WIDTH(CW), .DEPTH(MAX_LEN), .AW(AW)) u_row_ram (
    .clk(clk), .we(row_we), .waddr(wr_j_r[AW-1:0]), .wdata(cur),
    .re(row_re), .raddr(row_raddr), .rdata(row_rdata)
  );

  lcs_ram #(.WIDTH(DIR_W), .DEPTH(DDEPTH), .AW(DW)) u_dir_ram (
    .clk(clk), .we(dir_we), .waddr(cell_r), .wdata(dir_wdata),
    .re(dir_re), .raddr(tr_addr_r), .rdata(dir_rdata)
  );

  lcs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN), .AW(AW)) u_stk_ram (
    .clk(clk), .we(stk_we), .waddr(depth_r[AW-1:0]), .wdata(a_rdata),
    .re(stk_re), .raddr(ptr_r), .rdata(stk_rdata)
  );

  // ---- checks ----
  a_load_into_free_reg: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pop_out || cmd.empty_out) |-> (!out_valid_r || out_ready))
    else $error("output register overwritten before transfer");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stk_we |-> (depth_r < CW'(MAX_LEN)))
    else $error("result stack overflow");

  a_write_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fill_cell && v1_r) |-> (wr_j_r < b_cnt_r) && (wr_j_r < rd_j_r))
    else $error("cell write outside the current row");

endmodule

`default_nettype wire

// ===== hw/rtl/lcs_with_traceback_unit.sv =====
// ----------------------------------------------------------------------------
// lcs_with_traceback_unit
// Longest common subsequence of two byte strings, with traceback.
//
// Input channel in_ch: func LOAD_A / LOAD_B appends symbol to the first or
// second string (up to MAX_LEN each, extra symbols dropped); func START runs
// the table fill and traceback; func 3 is ignored.
// Output channel out_ch: the subsequence in forward order, one symbol per
// transfer, total_length on each, final_flag on the last. No common symbol
// gives one transfer with empty_flag and final_flag set.
// After START the fill computes one cell per cycle along a row, with a row
// setup state between rows; each traceback step reads and then evaluates the
// direction table, and each result is read from the stack and loaded when the
// output register is free. Input ready is low during that work; both strings
// are cleared once the final result is loaded. The output register holds a
// result while the receiver stalls; once the final result is loaded, new loads
// are taken meanwhile. Reset clears the string counts and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_with_traceback_unit import lcs_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lcs_in_if.sink     in_ch,
  lcs_out_if.source  out_ch
);

  cmd_t  cmd;
  stat_t stat;

  lcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lcs_dpath #(.MAX_LEN(MAX_LEN)) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_symbol    (in_ch.symbol),
    .out_ready    (out_ch.ready),
    .stat         (stat),
    .out_valid    (out_ch.valid),
    .out_symbol   (out_ch.out_symbol),
    .total_length (out_ch.total_length),
    .final_flag   (out_ch.final_flag),
    .empty_flag   (out_ch.empty_flag)
  );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lcs_with_traceback_unit. Loads pairs of byte
// strings, issues compute items and checks every subsequence symbol, length,
// last mark and empty mark against an in-bench LCS table fill and traceback.
// Short directed cases first, then random load/compute sequences under three
// idling regimes on the item and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lcs_pkg::*;

  localparam int MAX_LEN = MAX_LEN_DEF;
  localparam logic [FUNC_W-1:0] FUNC_IGNORED = 2'd3;
  localparam int RANDOM_ITEMS = 120;
  localparam int END_CYCLES = 50;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SYM_W-1:0]  symbol;
  } lcs_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] out_symbol;
    logic [TOT_W-1:0] total_length;
    logic             final_flag;
    logic             empty_flag;
  } lcs_result_t;

  logic clk;
  logic rst_n;

  lcs_in_if  in_ch();
  lcs_out_if out_ch();

  lcs_with_traceback_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------- shadow state of the block ----------------
  logic [SYM_W-1:0] first_str  [MAX_LEN];
  logic [SYM_W-1:0] second_str [MAX_LEN];
  int               first_len;
  int               second_len;
  logic [DIR_W-1:0] step_dir   [MAX_LEN][MAX_LEN];

  lcs_item_t   pending_items[$];
  lcs_result_t expected_results[$];

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  in_fire;
  int  error_count;
  int  accepted_items;
  int  compute_runs;
  int  results_checked;
  int  longest_found;
  int  random_items;
  lcs_item_t   next_item;
  lcs_result_t exp_res;

  // Table fill with diagonal on match, up only on strictly greater, else left;
  // traceback from the last cell, emitted in forward order.
  function automatic void compute_subsequence();
    int prev_row [MAX_LEN+1];
    int cur_row  [MAX_LEN+1];
    logic [SYM_W-1:0] found [MAX_LEN];
    int r;
    int c;
    int depth;
    lcs_result_t res;
    for (c = 0; c <= MAX_LEN; c++) begin
      prev_row[c] = 0;
      cur_row[c]  = 0;
    end
    for (r = 1; r <= first_len; r++) begin
      cur_row[0] = 0;
      for (c = 1; c <= second_len; c++) begin
        if (first_str[r-1] == second_str[c-1]) begin
          cur_row[c] = prev_row[c-1] + 1;
          step_dir[r-1][c-1] = DIR_DIAG;
        end else if (prev_row[c] > cur_row[c-1]) begin
          cur_row[c] = prev_row[c];
          step_dir[r-1][c-1] = DIR_UP;
        end else begin
          cur_row[c] = cur_row[c-1];
          step_dir[r-1][c-1] = DIR_LEFT;
        end
      end
      prev_row = cur_row;
    end
    depth = 0;
    r = first_len;
    c = second_len;
    while (r > 0 && c > 0) begin
      if (step_dir[r-1][c-1] == DIR_DIAG) begin
        if (depth < MAX_LEN) begin
          found[depth] = first_str[r-1];
          depth++;
        end
        r--;
        c--;
      end else if (step_dir[r-1][c-1] == DIR_UP) begin
        r--;
      end else begin
        c--;
      end
    end
    first_len  = 0;
    second_len = 0;
    compute_runs++;
    if (depth > longest_found) longest_found = depth;
    if (depth == 0) begin
      res = '{out_symbol: '0, total_length: '0, final_flag: 1'b1, empty_flag: 1'b1};
      expected_results.push_back(res);
    end else begin
      for (int k = 0; k < depth; k++) begin
        res.out_symbol   = found[depth-1-k];
        res.total_length = TOT_W'(depth);
        res.final_flag   = (k + 1 == depth);
        res.empty_flag   = 1'b0;
        expected_results.push_back(res);
      end
    end
  endfunction

  function automatic void apply_item(lcs_item_t it);
    case (it.func)
      FUNC_LOAD_A: begin
        if (first_len < MAX_LEN) begin
          first_str[first_len] = it.symbol;
          first_len++;
        end
      end
      FUNC_LOAD_B: begin
        if (second_len < MAX_LEN) begin
          second_str[second_len] = it.symbol;
          second_len++;
        end
      end
      FUNC_START: compute_subsequence();
      default: ;
    endcase
  endfunction

  // ---------------- item driver ----------------
  always @(posedge clk) begin
    in_fire = rst_n && in_ch.valid && in_ch.ready;
    if (in_fire) begin
      accepted_items++;
      apply_item(lcs_item_t'{func: in_ch.func, symbol: in_ch.symbol});
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = pending_items.pop_front();
        in_ch.valid  <= 1'b1;
        in_ch.func   <= next_item.func;
        in_ch.symbol <= next_item.symbol;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------- result monitor ----------------
  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $error("unexpected result transfer: out_symbol %0d total_length %0d",
               out_ch.out_symbol, out_ch.total_length);
      end else begin
        exp_res = expected_results.pop_front();
        results_checked++;
        if (out_ch.out_symbol !== exp_res.out_symbol) begin
          error_count++;
          $error("out_symbol: expected %0d, actual %0d",
                 exp_res.out_symbol, out_ch.out_symbol);
        end
        if (out_ch.total_length !== exp_res.total_length) begin
          error_count++;
          $error("total_length: expected %0d, actual %0d",
                 exp_res.total_length, out_ch.total_length);
        end
        if (out_ch.final_flag !== exp_res.final_flag) begin
          error_count++;
          $error("final_flag: expected %0d, actual %0d",
                 exp_res.final_flag, out_ch.final_flag);
        end
        if (out_ch.empty_flag !== exp_res.empty_flag) begin
          error_count++;
          $error("empty_flag: expected %0d, actual %0d",
                 exp_res.empty_flag, out_ch.empty_flag);
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic push_item(logic [FUNC_W-1:0] func, logic [SYM_W-1:0] symbol);
    pending_items.push_back(lcs_item_t'{func: func, symbol: symbol});
  endtask

  // Loads of both strings interleaved at random, a sprinkle of ignored
  // selectors, then usually a compute. mirror makes the second string a copy.
  task automatic add_sequence(int len_a, int len_b, bit mirror, bit with_start);
    logic [SYM_W-1:0] alphabet [4];
    logic [SYM_W-1:0] str_a [$];
    logic [SYM_W-1:0] str_b [$];
    bit narrow;
    int alpha_n;
    narrow  = ($urandom_range(9) < 7);
    alpha_n = $urandom_range(2, 4);
    foreach (alphabet[i]) alphabet[i] = SYM_W'($urandom);
    for (int i = 0; i < len_a; i++)
      str_a.push_back(narrow ? alphabet[$urandom_range(alpha_n-1)] : SYM_W'($urandom));
    if (mirror) begin
      str_b = str_a;
    end else begin
      for (int i = 0; i < len_b; i++)
        str_b.push_back(narrow ? alphabet[$urandom_range(alpha_n-1)] : SYM_W'($urandom));
    end
    while (str_a.size() != 0 || str_b.size() != 0) begin
      if ($urandom_range(19) == 0) push_item(FUNC_IGNORED, SYM_W'($urandom));
      if (str_b.size() == 0 || (str_a.size() != 0 && $urandom_range(1) == 1))
        push_item(FUNC_LOAD_A, str_a.pop_front());
      else
        push_item(FUNC_LOAD_B, str_b.pop_front());
      random_items++;
    end
    if (with_start) begin
      push_item(FUNC_START, SYM_W'($urandom));
      random_items++;
    end
  endtask

  function automatic int pick_len();
    int roll;
    roll = $urandom_range(19);
    if (roll < 2) return 0;
    if (roll == 19) return $urandom_range(20, 40);
    return $urandom_range(1, 12);
  endfunction

  task automatic add_random_until(int target);
    while (random_items < target)
      add_sequence(pick_len(), pick_len(), 1'b0, $urandom_range(9) != 0);
  endtask

  // sender holds off until every expected result has been seen
  task automatic drain();
    while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.func   = FUNC_LOAD_A;
    in_ch.symbol = '0;
    out_ch.ready = 1'b0;
    first_len    = 0;
    second_len   = 0;
    send_idle_pct = 24;
    recv_idle_pct = 54;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // both strings empty, then one side empty
    push_item(FUNC_START, 8'hA5);
    push_item(FUNC_LOAD_A, 8'h00);
    push_item(FUNC_START, 8'h00);
    push_item(FUNC_LOAD_B, 8'hFF);
    push_item(FUNC_START, 8'hFF);
    // ignored selector between loads leaves the strings alone
    push_item(FUNC_LOAD_A, 8'hFF);
    push_item(FUNC_IGNORED, 8'h12);
    push_item(FUNC_LOAD_B, 8'hFF);
    push_item(FUNC_START, 8'h00);
    // crossed pair: tie at the corner resolves to the left
    push_item(FUNC_LOAD_A, 8'h00);
    push_item(FUNC_LOAD_A, 8'hFF);
    push_item(FUNC_LOAD_B, 8'hFF);
    push_item(FUNC_LOAD_B, 8'h00);
    push_item(FUNC_START, 8'h00);
    // nothing in common
    push_item(FUNC_LOAD_A, 8'h01);
    push_item(FUNC_LOAD_A, 8'h02);
    push_item(FUNC_LOAD_B, 8'h03);
    push_item(FUNC_START, 8'h00);
    // alternating patterns
    push_item(FUNC_LOAD_A, 8'h55);
    push_item(FUNC_LOAD_A, 8'hAA);
    push_item(FUNC_LOAD_A, 8'h55);
    push_item(FUNC_LOAD_B, 8'hAA);
    push_item(FUNC_LOAD_B, 8'h55);
    push_item(FUNC_LOAD_B, 8'hAA);
    push_item(FUNC_START, 8'h00);

    add_random_until(RANDOM_ITEMS / 3);
    drain();

    send_idle_pct = 54;
    recv_idle_pct = 24;
    // both strings overrun MAX_LEN and match fully: longest possible output
    add_sequence(MAX_LEN + 2, 0, 1'b1, 1'b1);
    add_random_until(2 * RANDOM_ITEMS / 3);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_until(RANDOM_ITEMS);
    add_sequence(pick_len(), pick_len(), 1'b0, 1'b1);
    drain();
    repeat (END_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      error_count++;
      $error("%0d expected results never arrived", expected_results.size());
    end
    $display("Accepted %0d items over %0d compute runs (%0d random loads/computes).",
             accepted_items, compute_runs, random_items);
    $display("Checked %0d result transfers; longest subsequence %0d symbols.",
             results_checked, longest_found);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
